// ===== rtl/rtype_alu_regfile_execute_top_macros.svh =====
// ----------------------------------------------------------------------------
// rtype_alu_regfile_execute_top_macros
// Assertion helpers for the R-type execute block.
// ----------------------------------------------------------------------------
`ifndef RTYPE_ALU_REGFILE_EXECUTE_TOP_MACROS_SVH
`define RTYPE_ALU_REGFILE_EXECUTE_TOP_MACROS_SVH
// Implication checked on every clock, off during reset.
`define RAX_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Same, but evaluated during reset as well.
`define RAX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/rax_pkg.sv =====
// ----------------------------------------------------------------------------
// rax_pkg
// Types, opcodes and constants for the R-type execute block.
// ----------------------------------------------------------------------------
`default_nettype none
package rax_pkg;
  localparam int unsigned NumRegs  = 32;
  localparam int unsigned XLen     = 64;
  localparam int unsigned IdxW     = 5;
  localparam logic [4:0]  LinkReg  = 5'd31;
  localparam logic [63:0] LinkOff  = 64'd8;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MULT = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
    OP_AND = 5'd5, OP_OR = 5'd6, OP_XOR = 5'd7, OP_NOR = 5'd8, OP_SLL = 5'd9,
    OP_SLLV = 5'd10, OP_SRL = 5'd11, OP_SRLV = 5'd12, OP_SRA = 5'd13,
    OP_SRAV = 5'd14, OP_SLT = 5'd15, OP_SLTU = 5'd16, OP_JR = 5'd17,
    OP_JALR = 5'd18, OP_LOAD = 5'd19
  } op_e;

  typedef struct packed {
    logic [4:0]  req_type;
    logic [4:0]  rs_index;
    logic [4:0]  rt_index;
    logic [4:0]  rd_index;
    logic [5:0]  shift_amount;
    logic [63:0] pc_value;
    logic [63:0] load_value;
  } req_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic        jump_taken;
    logic [63:0] next_pc;
    logic        div_zero;
  } rsp_t;

  // divider control between top and divide unit
  typedef struct packed {
    logic start;
    logic is_mod;
  } div_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/rax_ram.sv =====
// ----------------------------------------------------------------------------
// rax_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module rax_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/rax_mul.sv =====
// ----------------------------------------------------------------------------
// rax_mul
// 64x64 low-half multiplier built from 32x32 partial products, summed in turn.
// ----------------------------------------------------------------------------
`default_nettype none
module rax_mul (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             done_o,
  output logic [63:0]      prod_o
);
  logic [1:0]  step_q, step_d;
  logic [63:0] a_q, b_q, acc_q, acc_d;
  logic [63:0] pp;

  always_comb begin
    unique case (step_q)
      2'd1:    pp = 64'(a_q[31:0]) * 64'(b_q[31:0]);
      2'd2:    pp = {(a_q[31:0] * b_q[63:32]), 32'd0};
      default: pp = {(a_q[63:32] * b_q[31:0]), 32'd0};
    endcase
    acc_d  = (step_q == 2'd1) ? pp : acc_q + pp;
    step_d = start_i ? 2'd1 : ((step_q == 2'd0 || step_q == 2'd3) ? 2'd0 : step_q + 2'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      done_o <= 1'b0;
    end else begin
      step_q <= step_d;
      done_o <= (step_q == 2'd3);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (step_q != 2'd0) acc_q <= acc_d;
  end

  assign prod_o = acc_q;
endmodule
`default_nettype wire

// ===== rtl/rax_div.sv =====
// ----------------------------------------------------------------------------
// rax_div
// Signed 64-bit divide/modulo, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rax_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rax_pkg::div_ctl_t ctl_i,
  input  wire logic [63:0]       a_i,
  input  wire logic [63:0]       b_i,
  output logic                   done_o,
  output logic [63:0]            res_o
);
  logic [6:0]  cnt_q;
  logic        busy_q, neg_q, mod_q;
  logic [63:0] quo_q, rem_q, den_q;
  logic [64:0] trial;
  logic [63:0] rem_sh;
  logic [63:0] fin;

  assign rem_sh = {rem_q[62:0], quo_q[63]};
  assign trial  = {1'b0, rem_sh} - {1'b0, den_q};
  assign fin    = mod_q ? rem_q : quo_q;
  assign res_o  = neg_q ? (64'd0 - fin) : fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      quo_q <= a_i[63] ? 64'd0 - a_i : a_i;
      den_q <= b_i[63] ? 64'd0 - b_i : b_i;
      rem_q <= '0;
      mod_q <= ctl_i.is_mod;
      neg_q <= ctl_i.is_mod ? a_i[63] : (a_i[63] ^ b_i[63]);
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_q <= trial[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rtype_alu_regfile_execute_top.sv =====
// ----------------------------------------------------------------------------
// rtype_alu_regfile_execute_top
// Executes 64-bit R-type ops against a 32x64 register file held in RAM.
// ----------------------------------------------------------------------------
// Flow: read, execute, write back for most ops; mult adds a wait on the
// 3-step multiplier, div/mod a wait on the divider (one quotient bit per
// cycle). One item at a time: the next transfer is taken only once the
// previous one is finished; busy stays high meanwhile.
// Reset: a clearing pass writes zero to all NumRegs entries, one per cycle,
// with busy high. Results cannot stall.
`default_nettype none
module rtype_alu_regfile_execute_top #(
  parameter int unsigned NumRegs = rax_pkg::NumRegs
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire rax_pkg::req_t req_i,
  output logic               done_o,
  output rax_pkg::rsp_t      rsp_o
);
  localparam int unsigned AW = $clog2(NumRegs);

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001, S_IDLE = 6'b000010, S_READ = 6'b000100,
    S_EXE  = 6'b001000, S_WAIT = 6'b010000, S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [AW:0]     clr_q;
  rax_pkg::req_t   req_q;
  logic [63:0]     a, b, a_rd, b_rd, res_q, res_d;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [63:0]     wdata;
  logic            mul_start, mul_done, div_done;
  logic [63:0]     mul_p, div_r;
  rax_pkg::div_ctl_t div_ctl;
  rax_pkg::op_e    op;
  logic            bzero;
  rax_pkg::rsp_t   rsp_d;
  logic            res_dz_q;

  assign op    = rax_pkg::op_e'(req_q.req_type);
  assign a     = a_rd;
  assign b     = b_rd;
  assign bzero = (b == 64'd0);

  // jalr: link write happens before rs read, so forward it
  logic [63:0] link;
  assign link = req_q.pc_value + rax_pkg::LinkOff;

  // read at the transfer edge from the incoming item, afterwards from the held one
  logic [AW-1:0] rs_addr, rt_addr;
  assign rs_addr = (state_q == S_IDLE) ? req_i.rs_index[AW-1:0] : req_q.rs_index[AW-1:0];
  assign rt_addr = (state_q == S_IDLE) ? req_i.rt_index[AW-1:0] : req_q.rt_index[AW-1:0];

  rax_ram #(.Width(64), .Depth(NumRegs)) u_ram_rs (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(rs_addr), .rdata_o(a_rd));
  rax_ram #(.Width(64), .Depth(NumRegs)) u_ram_rt (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(rt_addr), .rdata_o(b_rd));

  assign mul_start     = (state_q == S_EXE) && (op == rax_pkg::OP_MULT);
  assign div_ctl.start = (state_q == S_EXE) && !bzero &&
                         (op == rax_pkg::OP_DIV || op == rax_pkg::OP_MOD);
  assign div_ctl.is_mod = (op == rax_pkg::OP_MOD);

  rax_mul u_mul (.clk_i, .rst_ni, .start_i(mul_start), .a_i(a), .b_i(b),
                 .done_o(mul_done), .prod_o(mul_p));
  rax_div u_div (.clk_i, .rst_ni, .ctl_i(div_ctl), .a_i(a), .b_i(b),
                 .done_o(div_done), .res_o(div_r));

  logic [63:0] alu;
  logic        wr_en;
  always_comb begin
    alu   = '0;
    wr_en = 1'b1;
    unique case (op)
      rax_pkg::OP_ADD:  alu = a + b;
      rax_pkg::OP_SUB:  alu = a - b;
      rax_pkg::OP_AND:  alu = a & b;
      rax_pkg::OP_OR:   alu = a | b;
      rax_pkg::OP_XOR:  alu = a ^ b;
      rax_pkg::OP_NOR:  alu = ~(a | b);
      rax_pkg::OP_SLL:  alu = b << req_q.shift_amount;
      rax_pkg::OP_SLLV: alu = (b > 64'd63) ? 64'd0 : a << b[5:0];
      rax_pkg::OP_SRL:  alu = b >> req_q.shift_amount;
      rax_pkg::OP_SRLV: alu = (b > 64'd63) ? 64'd0 : a >> b[5:0];
      rax_pkg::OP_SRA:  alu = 64'($signed(b) >>> req_q.shift_amount);
      rax_pkg::OP_SRAV: alu = 64'($signed(a) >>> b[5:0]);
      rax_pkg::OP_SLT:  alu = {63'd0, $signed(a) < $signed(b)};
      rax_pkg::OP_SLTU: alu = {63'd0, a < b};
      rax_pkg::OP_JALR: alu = link;
      rax_pkg::OP_LOAD: alu = req_q.load_value;
      rax_pkg::OP_MULT, rax_pkg::OP_DIV, rax_pkg::OP_MOD: alu = '0;
      default:          wr_en = 1'b0; // jr and unused codes
    endcase
  end

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    unique case (state_q)
      S_CLR:  if (clr_q == (AW+1)'(NumRegs - 1)) state_d = S_IDLE;
      S_IDLE: if (start) state_d = S_READ;
      S_READ: state_d = S_EXE;
      S_EXE: begin
        res_d = alu;
        if (op == rax_pkg::OP_MULT ||
            ((op == rax_pkg::OP_DIV || op == rax_pkg::OP_MOD) && !bzero))
          state_d = S_WAIT;
        else state_d = S_DONE;
      end
      S_WAIT: begin
        if (mul_done) begin
          res_d = mul_p; state_d = S_DONE;
        end else if (div_done) begin
          res_d = div_r; state_d = S_DONE;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_CLR;
    endcase
  end

  // write back in S_DONE; clearing pass in S_CLR
  logic wb;
  assign wb    = (state_q == S_DONE) && wr_en;
  assign we    = (state_q == S_CLR) || wb;
  assign waddr = (state_q == S_CLR) ? clr_q[AW-1:0] :
                 (op == rax_pkg::OP_JALR) ? rax_pkg::LinkReg[AW-1:0] :
                 req_q.rd_index[AW-1:0];
  assign wdata = (state_q == S_CLR) ? 64'd0 : res_q;

  logic jmp;
  assign jmp = (op == rax_pkg::OP_JR) || (op == rax_pkg::OP_JALR);
  // jump target is captured in S_EXE while the rs read data is valid
  logic [63:0] npc_q;

  always_comb begin
    rsp_d.result_value = wr_en ? res_q : 64'd0;
    rsp_d.reg_written  = wr_en;
    rsp_d.dest_index   = !wr_en ? 5'd0 :
                         (op == rax_pkg::OP_JALR) ? rax_pkg::LinkReg : req_q.rd_index;
    rsp_d.jump_taken   = jmp;
    rsp_d.next_pc      = jmp ? npc_q : 64'd0;
    rsp_d.div_zero     = (op == rax_pkg::OP_DIV || op == rax_pkg::OP_MOD) && res_dz_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + 1'b1;
      done_o <= (state_q == S_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (start && !busy) req_q <= req_i;
    if (state_q == S_EXE) begin
      res_dz_q <= bzero;
      npc_q    <= ((op == rax_pkg::OP_JALR) &&
                   (req_q.rs_index == rax_pkg::LinkReg)) ? link : a;
    end
    if (state_q == S_DONE) rsp_o <= rsp_d;
  end

  assign busy = (state_q != S_IDLE);
endmodule
`default_nettype wire

// ===== rtl/rax_checker.sv =====
// ----------------------------------------------------------------------------
// rax_checker
// Port-level checks for the R-type execute block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rtype_alu_regfile_execute_top_macros.svh"
module rax_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done_o,
  input wire rax_pkg::rsp_t rsp_o
);
  logic jr_seen;
  assign jr_seen = done_o && rsp_o.jump_taken && !rsp_o.reg_written;

  `RAX_ASSERT(a_take_busy, clk_i, rst_ni, (start && !busy) |=> busy, "no busy after transfer")
  `RAX_ASSERT(a_done_busy, clk_i, rst_ni, done_o |-> $past(busy), "result without work")
  `RAX_ASSERT(a_done_pulse, clk_i, rst_ni, done_o |=> !done_o, "result repeated")
  `RAX_ASSERT(a_jr_nowr, clk_i, rst_ni, jr_seen |-> (rsp_o.result_value == 64'd0), "jr wrote")
  `RAX_ASSERT_ALWAYS(a_rst_busy, clk_i, !rst_ni |-> busy, "idle in reset")
endmodule
bind rtype_alu_regfile_execute_top rax_checker u_rax_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .rsp_o);
`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Random and directed test of the R-type execute block: a register-file
// predictor computes each result, a scoreboard checks every done strobe.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 4000;
  localparam logic [63:0] MinNeg = 64'h8000_0000_0000_0000;

  class exec_scoreboard;
    logic [63:0]   regs [32];
    rax_pkg::rsp_t pending [$];
    int unsigned   mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      mismatches = 0;
    endfunction

    // Predict the result of one accepted transfer and update the register copy.
    function void note_req(rax_pkg::req_t r);
      logic [63:0]   a, b, val, q, m;
      rax_pkg::rsp_t p;
      a = regs[r.rs_index];
      b = regs[r.rt_index];
      p = '0;
      p.reg_written = 1'b1;
      p.dest_index  = r.rd_index;
      val = '0;
      case (r.req_type)
        rax_pkg::OP_ADD:  val = a + b;
        rax_pkg::OP_SUB:  val = a - b;
        rax_pkg::OP_MULT: val = a * b;
        rax_pkg::OP_DIV, rax_pkg::OP_MOD: begin
          if (b == 0) begin
            p.div_zero = 1'b1;
          end else begin
            q = a[63] ? -a : a;
            m = b[63] ? -b : b;
            if (r.req_type == rax_pkg::OP_DIV) begin
              val = q / m;
              if (a[63] ^ b[63]) val = -val;
            end else begin
              val = q % m;
              if (a[63]) val = -val;
            end
          end
        end
        rax_pkg::OP_AND:  val = a & b;
        rax_pkg::OP_OR:   val = a | b;
        rax_pkg::OP_XOR:  val = a ^ b;
        rax_pkg::OP_NOR:  val = ~(a | b);
        rax_pkg::OP_SLL:  val = b << r.shift_amount;
        rax_pkg::OP_SLLV: val = (b <= 63) ? a << b[5:0] : '0;
        rax_pkg::OP_SRL:  val = b >> r.shift_amount;
        rax_pkg::OP_SRLV: val = (b <= 63) ? a >> b[5:0] : '0;
        rax_pkg::OP_SRA:  val = $signed(b) >>> r.shift_amount;
        rax_pkg::OP_SRAV: val = $signed(a) >>> b[5:0];
        rax_pkg::OP_SLT:  val = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
        rax_pkg::OP_SLTU: val = (a < b) ? 64'd1 : 64'd0;
        rax_pkg::OP_JR: begin
          p.reg_written = 1'b0;
          p.dest_index  = '0;
          p.jump_taken  = 1'b1;
          p.next_pc     = a;
        end
        rax_pkg::OP_JALR: begin
          val = r.pc_value + rax_pkg::LinkOff;
          regs[rax_pkg::LinkReg] = val;
          p.dest_index = rax_pkg::LinkReg;
          p.jump_taken = 1'b1;
          p.next_pc    = regs[r.rs_index];
        end
        rax_pkg::OP_LOAD: val = r.load_value;
        default: begin
          p.reg_written = 1'b0;
          p.dest_index  = '0;
        end
      endcase
      if (p.reg_written) begin
        p.result_value = val;
        if (r.req_type != rax_pkg::OP_JALR) regs[r.rd_index] = val;
      end
      pending.push_back(p);
    endfunction

    function void check_rsp(rax_pkg::rsp_t got);
      rax_pkg::rsp_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got.result_value !== exp.result_value || got.reg_written !== exp.reg_written ||
          got.dest_index !== exp.dest_index || got.jump_taken !== exp.jump_taken ||
          got.next_pc !== exp.next_pc || got.div_zero !== exp.div_zero) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp val=%h wr=%b rd=%0d j=%b pc=%h dz=%b",
                   exp.result_value, exp.reg_written, exp.dest_index,
                   exp.jump_taken, exp.next_pc, exp.div_zero,
                   "\n          got val=%h wr=%b rd=%0d j=%b pc=%h dz=%b",
                   got.result_value, got.reg_written, got.dest_index,
                   got.jump_taken, got.next_pc, got.div_zero);
      end
    endfunction
  endclass

  logic clk_i, rst_ni, start, busy, done_o;
  rax_pkg::req_t req_i;
  rax_pkg::rsp_t rsp_o;
  exec_scoreboard sb;
  int unsigned idle_cycles = 0;

  rtype_alu_regfile_execute_top dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .done_o, .rsp_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sample transfers and results at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (start && !busy) sb.note_req(req_i);
      if (done_o) sb.check_rsp(rsp_o);
      if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand_val();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = MinNeg;
      2: v = '1;
      3: v = 64'(int'($urandom_range(0, 80)) - 8);
      4: v = v >> $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  // Drive one transfer: optional gap, then hold start until accepted.
  task automatic send(rax_pkg::req_t r);
    repeat ($urandom_range(0, 16) < 6 ? 0 : $urandom_range(0, 16)) @(negedge clk_i);
    req_i = r;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic load(logic [4:0] rd, logic [63:0] v);
    rax_pkg::req_t r;
    r = '0;
    r.req_type   = rax_pkg::OP_LOAD;
    r.rd_index   = rd;
    r.load_value = v;
    send(r);
  endtask

  task automatic op(logic [4:0] t, logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                    logic [5:0] sh);
    rax_pkg::req_t r;
    r = '0;
    r.req_type = t; r.rs_index = rs; r.rt_index = rt; r.rd_index = rd;
    r.shift_amount = sh;
    r.pc_value = rand_val();
    r.load_value = rand_val();
    send(r);
  endtask

  initial begin
    rax_pkg::req_t r;
    sb = new();
    start = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: divide overflow, divide by zero, shift ranges, jalr link read.
    load(5'd1, MinNeg);
    load(5'd2, '1);
    load(5'd3, 64'd64);
    load(5'd4, 64'd63);
    op(rax_pkg::OP_DIV, 5'd1, 5'd2, 5'd5, 6'd0);
    op(rax_pkg::OP_MOD, 5'd1, 5'd2, 5'd6, 6'd0);
    op(rax_pkg::OP_DIV, 5'd1, 5'd0, 5'd7, 6'd0);
    op(rax_pkg::OP_MOD, 5'd2, 5'd0, 5'd7, 6'd0);
    op(rax_pkg::OP_SLLV, 5'd2, 5'd3, 5'd8, 6'd0);
    op(rax_pkg::OP_SRLV, 5'd2, 5'd4, 5'd8, 6'd0);
    op(rax_pkg::OP_SRLV, 5'd2, 5'd2, 5'd8, 6'd0);
    op(rax_pkg::OP_SRAV, 5'd1, 5'd3, 5'd9, 6'd0);
    op(rax_pkg::OP_SRA, 5'd0, 5'd1, 5'd9, 6'd63);
    op(rax_pkg::OP_SLT, 5'd1, 5'd2, 5'd10, 6'd0);
    op(rax_pkg::OP_SLTU, 5'd1, 5'd2, 5'd10, 6'd0);
    op(rax_pkg::OP_JALR, 5'd31, 5'd0, 5'd0, 6'd0);
    op(rax_pkg::OP_JR, 5'd2, 5'd0, 5'd0, 6'd0);
    op(5'd31, 5'd1, 5'd2, 5'd3, 6'd0);
    op(rax_pkg::OP_ADD, 5'd1, 5'd1, 5'd0, 6'd0);
    op(rax_pkg::OP_MULT, 5'd2, 5'd2, 5'd11, 6'd0);

    for (int i = 0; i < 2000; i++) begin
      r.rs_index = 5'($urandom_range(0, 31));
      r.rt_index = 5'($urandom_range(0, 31));
      r.rd_index = 5'($urandom_range(0, 31));
      if ($urandom_range(0, 3) == 0) load(r.rd_index, rand_val());
      else op(($urandom_range(0, 15) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(0, 18)),
              r.rs_index, r.rt_index, r.rd_index, 6'($urandom_range(0, 63)));
    end

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== rtype_alu_regfile_execute_top.f =====
+incdir+rtl
rtl/rax_pkg.sv
rtl/rax_ram.sv
rtl/rax_mul.sv
rtl/rax_div.sv
rtl/rtype_alu_regfile_execute_top.sv
rtl/rax_checker.sv
tb/tb_top.sv
